### design/bcpe_pkg.sv
// shared types and helpers for the bezier curve point evaluator
`default_nettype none

package bcpe_pkg;

  // input word
  typedef struct packed {
    logic               op;
    logic        [3:0]  point_index;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic        [16:0] curve_param;
  } bcpe_in_t;

  // result word
  typedef struct packed {
    logic signed [23:0] curve_x;
    logic signed [23:0] curve_y;
  } bcpe_out_t;

  // control point as stored, whole pixels
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } bcpe_point_t;

  // working point, q15.8 pixels
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
  } bcpe_work_t;

  // control from the sequencer to the interpolation datapath
  typedef struct packed {
    logic ld_diff;
    logic mul_en;
    logic mul_y;
    logic sum_x_en;
    logic sum_y;
  } bcpe_lerp_ctl_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam int          CFG_W  = 5;
  localparam int          T_W    = 17;
  localparam logic [16:0] T_ONE  = 17'h10000;
  localparam int          PROD_W = 43;

  // whole pixels to q15.8
  function automatic bcpe_work_t to_work(input bcpe_point_t p);
    bcpe_work_t w;
    w.x = {p.x, 8'h00};
    w.y = {p.y, 8'h00};
    return w;
  endfunction

endpackage

`default_nettype wire

### design/bcpe_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module bcpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/bcpe_lerp.sv
// interpolation datapath: difference, one shared multiplier, rounding add
`default_nettype none

module bcpe_lerp (
  input  wire logic                    clk,
  input  wire bcpe_pkg::bcpe_lerp_ctl_t ctl,
  input  wire bcpe_pkg::bcpe_work_t    p,
  input  wire bcpe_pkg::bcpe_work_t    q,
  input  wire logic [16:0]             t,
  output logic signed [23:0]           res_x,
  output logic signed [23:0]           sum
);

  logic signed [24:0] dx_r;
  logic signed [24:0] dy_r;
  logic signed [bcpe_pkg::PROD_W-1:0] prod_r;
  logic signed [bcpe_pkg::PROD_W-1:0] prod_nxt;
  logic signed [bcpe_pkg::PROD_W-1:0] rnd;
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [23:0] p_sel;
  logic signed [23:0] res_x_r;

  // operand select and product
  always_comb begin
    mul_a    = ctl.mul_y ? dy_r : dx_r;
    mul_b    = signed'({1'b0, t});
    prod_nxt = mul_a * mul_b;
  end

  // p + floor(d*t / 65536 + 0.5); the blend stays inside 24 bits
  always_comb begin
    p_sel = ctl.sum_y ? p.y : p.x;
    rnd   = prod_r + bcpe_pkg::PROD_W'(32768);
    sum   = p_sel + rnd[39:16];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_diff) begin
      dx_r <= {q.x[23], q.x} - {p.x[23], p.x};
      dy_r <= {q.y[23], q.y} - {p.y[23], p.y};
    end
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.sum_x_en) begin
      res_x_r <= sum;
    end
  end

  assign res_x = res_x_r;

endmodule

`default_nettype wire

### design/bezier_curve_point_evaluator_unit.sv
// top level: bezier curve point evaluator with control point and work rams
//
// Input channel (in_valid, in_stall, in_data): a word with op write stores one
// control point in the control point ram and gives no result; op evaluate runs
// de Casteljau interpolation on the first point_count points at t and gives
// one curve point in q15.8 on the output channel (out_valid, out_stall,
// out_data). Config channel (cfg_valid, cfg_ready, cfg_data) sets point_count.
// One word is in flight at a time; in_stall is high while an evaluation runs.
// A write is stored as it is accepted. An evaluation of n points first copies
// the points into the work ram, then runs each level 1..n-1 (read and load of
// the first point, then n-level interpolations), then loads the output
// register, and a new word is taken after that. Each interpolation runs the
// difference, x product, y product and write back steps on the one shared
// multiplier; the work ram has one read and one write port.
// The result sits in an output register, so a new word is taken while the
// receiver stalls; a finished evaluation waits there until the slot is free.
// Reset sets point_count to 1 and empties the output; ram contents stay
// undefined, and control points must be written before they are used.
`default_nettype none

module bezier_curve_point_evaluator_unit #(
  parameter int MAX_POINTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bcpe_pkg::bcpe_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bcpe_pkg::bcpe_out_t     out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [bcpe_pkg::CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CP_RD  = 4'd1;
  localparam logic [3:0] ST_CP_WR  = 4'd2;
  localparam logic [3:0] ST_LV_RD0 = 4'd3;
  localparam logic [3:0] ST_LV_LD0 = 4'd4;
  localparam logic [3:0] ST_MX     = 4'd5;
  localparam logic [3:0] ST_P0     = 4'd6;
  localparam logic [3:0] ST_P1     = 4'd7;
  localparam logic [3:0] ST_WR     = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_load;
  logic [bcpe_pkg::CFG_W-1:0] point_count_r;

  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] lvl_r, lvl_nxt;
  logic [CW-1:0] n_r, n_nxt, n_clamp;
  logic [16:0]   t_r, t_nxt;
  bcpe_pkg::bcpe_work_t p_r, p_nxt;
  bcpe_pkg::bcpe_work_t q_r, q_nxt;
  bcpe_pkg::bcpe_work_t res_r, res_nxt;
  bcpe_pkg::bcpe_out_t  out_data_r;

  logic                  cp_we;
  logic [AW-1:0]         cp_waddr, cp_raddr;
  bcpe_pkg::bcpe_point_t cp_wdata, cp_rdata;
  logic                  wk_we;
  logic [AW-1:0]         wk_waddr, wk_raddr;
  bcpe_pkg::bcpe_work_t  wk_wdata, wk_rdata;

  bcpe_pkg::bcpe_lerp_ctl_t lerp_ctl;
  logic signed [23:0]       lerp_res_x;
  logic signed [23:0]       lerp_sum;

  logic in_accept;
  logic idx_ok;
  logic copy_last;
  logic level_last;
  logic lvl_final;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // storage: control points and interpolation scratch
  bcpe_ram #(
    .WIDTH ($bits(bcpe_pkg::bcpe_point_t)),
    .DEPTH (MAX_POINTS)
  ) u_cp_ram (
    .clk   (clk),
    .we    (cp_we),
    .waddr (cp_waddr),
    .wdata (cp_wdata),
    .raddr (cp_raddr),
    .rdata (cp_rdata)
  );

  bcpe_ram #(
    .WIDTH ($bits(bcpe_pkg::bcpe_work_t)),
    .DEPTH (MAX_POINTS)
  ) u_wk_ram (
    .clk   (clk),
    .we    (wk_we),
    .waddr (wk_waddr),
    .wdata (wk_wdata),
    .raddr (wk_raddr),
    .rdata (wk_rdata)
  );

  bcpe_lerp u_lerp (
    .clk   (clk),
    .ctl   (lerp_ctl),
    .p     (p_r),
    .q     (wk_rdata),
    .t     (t_r),
    .res_x (lerp_res_x),
    .sum   (lerp_sum)
  );

  // point count clamped to 1..MAX_POINTS
  always_comb begin
    if (point_count_r == '0) begin
      n_clamp = CW'(1);
    end else if (int'(point_count_r) > MAX_POINTS) begin
      n_clamp = CW'(MAX_POINTS);
    end else begin
      n_clamp = CW'(point_count_r);
    end
  end

  // loop end conditions
  assign idx_ok     = int'(in_data.point_index) < MAX_POINTS;
  assign copy_last  = (CW'(idx_r) + CW'(1)) == n_r;
  assign level_last = (CW'(idx_r) + CW'(lvl_r) + CW'(1)) == n_r;
  assign lvl_final  = (CW'(lvl_r) + CW'(1)) == n_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    lvl_nxt   = lvl_r;
    n_nxt     = n_r;
    t_nxt     = t_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    res_nxt   = res_r;
    out_load  = 1'b0;
    cp_we     = 1'b0;
    cp_waddr  = AW'(in_data.point_index);
    cp_wdata  = '{x: in_data.point_x, y: in_data.point_y};
    cp_raddr  = idx_r;
    wk_we     = 1'b0;
    wk_waddr  = idx_r;
    wk_wdata  = bcpe_pkg::to_work(cp_rdata);
    wk_raddr  = '0;
    lerp_ctl  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.op == bcpe_pkg::OP_WRITE) begin
            cp_we = idx_ok;
          end else begin
            n_nxt     = n_clamp;
            t_nxt     = (in_data.curve_param > bcpe_pkg::T_ONE) ?
                        bcpe_pkg::T_ONE : in_data.curve_param;
            idx_nxt   = '0;
            state_nxt = ST_CP_RD;
          end
        end
      end
      ST_CP_RD: begin
        state_nxt = ST_CP_WR;
      end
      ST_CP_WR: begin
        wk_we = 1'b1;
        if (copy_last) begin
          if (n_r == CW'(1)) begin
            res_nxt   = wk_wdata;
            state_nxt = ST_FIN;
          end else begin
            lvl_nxt   = AW'(1);
            idx_nxt   = '0;
            state_nxt = ST_LV_RD0;
          end
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_CP_RD;
        end
      end
      ST_LV_RD0: begin
        wk_raddr  = '0;
        state_nxt = ST_LV_LD0;
      end
      ST_LV_LD0: begin
        p_nxt     = wk_rdata;
        wk_raddr  = AW'(idx_r + AW'(1));
        state_nxt = ST_MX;
      end
      ST_MX: begin
        lerp_ctl.ld_diff = 1'b1;
        q_nxt            = wk_rdata;
        state_nxt        = ST_P0;
      end
      ST_P0: begin
        lerp_ctl.mul_en = 1'b1;
        state_nxt       = ST_P1;
      end
      ST_P1: begin
        lerp_ctl.mul_en   = 1'b1;
        lerp_ctl.mul_y    = 1'b1;
        lerp_ctl.sum_x_en = 1'b1;
        state_nxt         = ST_WR;
      end
      ST_WR: begin
        lerp_ctl.sum_y = 1'b1;
        wk_we          = 1'b1;
        wk_wdata       = '{x: lerp_res_x, y: lerp_sum};
        p_nxt          = q_r;
        if (level_last) begin
          if (lvl_final) begin
            res_nxt   = wk_wdata;
            state_nxt = ST_FIN;
          end else begin
            lvl_nxt   = lvl_r + AW'(1);
            idx_nxt   = '0;
            state_nxt = ST_LV_RD0;
          end
        end else begin
          idx_nxt   = idx_r + AW'(1);
          wk_raddr  = AW'(idx_r + AW'(2));
          state_nxt = ST_MX;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      point_count_r <= bcpe_pkg::CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        point_count_r <= cfg_data;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    lvl_r <= lvl_nxt;
    n_r   <= n_nxt;
    t_r   <= t_nxt;
    p_r   <= p_nxt;
    q_r   <= q_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r.curve_x <= res_r.x;
      out_data_r.curve_y <= res_r.y;
    end
  end

`ifndef SYNTHESIS
  // a result only appears after the final stage of an evaluation
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result appeared without a finished evaluation");

  // scratch writes stay inside the points in use
  a_wk_addr: assert property (@(posedge clk) disable iff (!rst_n)
    wk_we |-> (CW'(wk_waddr) < n_r))
    else $error("work ram write beyond point count");

  // a control point write never starts a sequence
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.op == bcpe_pkg::OP_WRITE) |=> (state_r == ST_IDLE))
    else $error("write word left the block busy");

  // the level counter never reaches the point count
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MX || state_r == ST_WR) |-> (CW'(lvl_r) < n_r))
    else $error("interpolation level out of range");
`endif

endmodule

`default_nettype wire

### bench/bezier_curve_point_evaluator_unit_tb.sv
// testbench for the bezier curve point evaluator: queued driver, predictor and checker
`timescale 1ns / 100ps

module bezier_curve_point_evaluator_unit_tb;

  localparam int NUM_POINTS  = 16;
  localparam int ITEM_TARGET = 450;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  bcpe_pkg::bcpe_in_t         in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  bcpe_pkg::bcpe_out_t        out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [bcpe_pkg::CFG_W-1:0] cfg_data = '0;

  // words waiting to be sent, curve points waiting to come back
  bcpe_pkg::bcpe_in_t  pending_words[$];
  bcpe_pkg::bcpe_out_t expected_points[$];

  // predictor state
  int signed                  ctrl_x[NUM_POINTS];
  int signed                  ctrl_y[NUM_POINTS];
  logic [bcpe_pkg::CFG_W-1:0] points_in_use = 5'd1;

  int fail_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit quiet_run = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  bezier_curve_point_evaluator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // one interpolation step in q15.8, rounded to nearest, ties upward
  function automatic longint signed lerp_q8(input longint signed p, input longint signed q,
                                            input longint signed t);
    return p + (((q - p) * t + 64'sd32768) >>> 16);
  endfunction

  // de casteljau over the points in use
  function automatic bcpe_pkg::bcpe_out_t eval_curve(input logic [bcpe_pkg::T_W-1:0] param);
    longint signed       wx[NUM_POINTS];
    longint signed       wy[NUM_POINTS];
    longint signed       t;
    int                  n;
    bcpe_pkg::bcpe_out_t r;
    t = (param > bcpe_pkg::T_ONE) ? longint'(bcpe_pkg::T_ONE) : longint'(param);
    n = (points_in_use == 0) ? 1 : ((points_in_use > NUM_POINTS) ? NUM_POINTS : points_in_use);
    for (int i = 0; i < n; i++) begin
      wx[i] = longint'(ctrl_x[i]) * 256;
      wy[i] = longint'(ctrl_y[i]) * 256;
    end
    for (int lvl = 1; lvl < n; lvl++) begin
      for (int i = 0; i + lvl < n; i++) begin
        wx[i] = lerp_q8(wx[i], wx[i + 1], t);
        wy[i] = lerp_q8(wy[i], wy[i + 1], t);
      end
    end
    r.curve_x = wx[0][23:0];
    r.curve_y = wy[0][23:0];
    return r;
  endfunction

  // update the predictor with a word the block has taken
  task automatic accept_word(input bcpe_pkg::bcpe_in_t w);
    if (w.op == bcpe_pkg::OP_WRITE) begin
      if (int'(w.point_index) < NUM_POINTS) begin
        ctrl_x[w.point_index] = w.point_x;
        ctrl_y[w.point_index] = w.point_y;
      end
    end else begin
      expected_points = {expected_points, eval_curve(w.curve_param)};
    end
  endtask

  // queue a word for the driver
  task automatic queue_word(input bcpe_pkg::bcpe_in_t w);
    pending_words = {pending_words, w};
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] want,
                                 input logic [23:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $realtime);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        accept_word(in_data);
      // a stalled word stays put
      if (!(in_valid && in_stall)) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (!quiet_run && $urandom_range(0, 15) == 0) begin
          in_valid <= 1'b0;
          send_gap = $urandom_range(0, 18);
        end else if (pending_words.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    bcpe_pkg::bcpe_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected word", 24'h0, out_data.curve_x);
      end else begin
        want = expected_points.pop_front();
        if (out_data.curve_x !== want.curve_x)
          report_mismatch("curve_x", want.curve_x, out_data.curve_x);
        if (out_data.curve_y !== want.curve_y)
          report_mismatch("curve_y", want.curve_y, out_data.curve_y);
      end
    end
  end

  // receiver back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (hold_request && !hold_done) begin
      out_stall <= 1'b1;
      stall_left = LONG_HOLD - 1;
      hold_done = 1'b1;
    end else if (!quiet_run && $urandom_range(0, 11) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [bcpe_pkg::T_W-1:0] rand_param();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return bcpe_pkg::T_ONE;
      2:       return bcpe_pkg::T_W'($urandom_range(65537, 131071));
      3:       return bcpe_pkg::T_W'($urandom_range(0, 15));
      4:       return bcpe_pkg::T_W'($urandom_range(65520, 65535));
      default: return bcpe_pkg::T_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic bcpe_pkg::bcpe_in_t write_word(input int idx, input logic [15:0] x,
                                                    input logic [15:0] y);
    bcpe_pkg::bcpe_in_t w;
    w.op          = bcpe_pkg::OP_WRITE;
    w.point_index = 4'(idx);
    w.point_x     = x;
    w.point_y     = y;
    w.curve_param = bcpe_pkg::T_W'($urandom);
    return w;
  endfunction

  function automatic bcpe_pkg::bcpe_in_t eval_word(input logic [bcpe_pkg::T_W-1:0] param);
    bcpe_pkg::bcpe_in_t w;
    w.op          = bcpe_pkg::OP_EVAL;
    w.point_index = 4'($urandom);
    w.point_x     = 16'($urandom);
    w.point_y     = 16'($urandom);
    w.curve_param = param;
    return w;
  endfunction

  // wait until every word has gone in and every result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_points.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_point_count(input logic [bcpe_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    points_in_use = v;
    @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    logic [bcpe_pkg::CFG_W-1:0] plan[$];
    logic [bcpe_pkg::CFG_W-1:0] v;
    int                         total;
    int                         k;
    int                         n_items;
    int                         eff;

    plan = {5'd2, 5'd0, 5'd31, 5'd3, 5'd2, 5'd5, 5'd17, 5'd8, 5'd4, 5'd1, 5'd6, 5'd16,
            5'd3, 5'd2, 5'd7};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single point from reset: extremes and parameter saturation
    queue_word(write_word(0, 16'h8000, 16'h7fff));
    for (int i = 1; i < NUM_POINTS; i++)
      queue_word(write_word(i, (i % 2) ? 16'h7fff : 16'h8000,
                            (i % 2) ? 16'h8000 : 16'h7fff));
    queue_word(eval_word('0));
    queue_word(eval_word(bcpe_pkg::T_ONE));
    queue_word(eval_word(17'h1ffff));
    queue_word(eval_word(17'h10001));
    wait_idle();

    // full sixteen-point curve at the edges and the midpoint of t
    set_point_count(5'd16);
    queue_word(eval_word('0));
    queue_word(eval_word(17'd1));
    queue_word(eval_word(17'd32768));
    queue_word(eval_word(17'd65535));
    wait_idle();

    // count of zero acts as one, counts above sixteen act as sixteen
    set_point_count(5'd0);
    queue_word(eval_word(17'd40000));
    wait_idle();
    set_point_count(5'd31);
    queue_word(eval_word(17'd12345));
    wait_idle();
    total = 26;

    // random phases over a range of point counts
    k = 0;
    while (total < ITEM_TARGET) begin
      if (ITEM_TARGET - total <= 45) begin
        quiet_run = 1'b1;
        v = 5'd3;
        n_items = ITEM_TARGET - total;
      end else begin
        v = plan[k % plan.size()];
        eff = (v == 0) ? 1 : ((v > NUM_POINTS) ? NUM_POINTS : v);
        n_items = (eff >= 12) ? 10 : 34;
      end
      set_point_count(v);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 9) < 4)
          queue_word(write_word($urandom_range(0, NUM_POINTS - 1),
                                rand_coord(), rand_coord()));
        else
          queue_word(eval_word(rand_param()));
      end
      // short curves with the receiver held off fill the block up
      if (k == 4)
        hold_request = 1'b1;
      wait_idle();
      total += n_items;
      k++;
    end

    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("bezier_curve_point_evaluator_unit verification clean");
    end else begin
      $display("bezier_curve_point_evaluator_unit verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6000000;
    $display("bezier_curve_point_evaluator_unit verification failed");
    $finish;
  end

endmodule
